>>> rtl/scad_pkg.sv
package scad_pkg;

  localparam int TABLE_ENTRIES = 96;

  // key codes (low 7 bits of the scan byte)
  localparam logic [6:0] KEY_CTRL     = 7'h1D;
  localparam logic [6:0] KEY_LSHIFT   = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT   = 7'h36;
  localparam logic [6:0] KEY_ALT      = 7'h38;
  localparam logic [6:0] KEY_CAPS     = 7'h3A;
  localparam logic [6:0] KEY_NUM      = 7'h45;
  localparam logic [6:0] KEY_SCROLL   = 7'h46;
  localparam logic [6:0] KEYPAD_FIRST = 7'h47;
  localparam logic [6:0] KEYPAD_LAST  = 7'h53;

  localparam logic [7:0] PREFIX_MIN   = 8'hE0;
  localparam logic [7:0] NULL_CODE    = 8'h00;

  localparam logic [6:0] ASCII_LC_A   = 7'h61;
  localparam logic [6:0] ASCII_LC_Z   = 7'h7A;

  // led_bits order (MSB first): caps, num, scroll
  localparam logic [2:0] LED_RESET    = 3'b010;

  typedef logic [6:0] ascii_t;

  localparam ascii_t SHIFT_MAP [TABLE_ENTRIES] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
    7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
    7'h32, 7'h33, 7'h30, 7'h2E, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  localparam ascii_t PLAIN_MAP [TABLE_ENTRIES] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h2D, 7'h00, 7'h00, 7'h00, 7'h2B, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

endpackage

>>> rtl/scan_code_to_ascii_decoder.sv
// Channel  | Handshake                  | Word
// ---------+----------------------------+----------------------------------------------
// scan     | scan_valid / scan_ready    | scan_code[7:0]
// result   | result_valid / result_ready| char_valid, char_code[6:0], led_write,
//          |                            | led_bits[2:0], shift_held, ctrl_held, alt_held
//
// One word in, one word out. Sustained rate is one word per cycle while result_ready stays high.
// Each word passes through the input register, then is decoded into the result register.
// The decode reads and updates the key/lock flags in the same cycle, so the flags
// always match the word held in the result register.
// scan_ready = input register empty or moving on; a stalled result holds both stages.
// Synchronous reset empties both stages and sets num lock, all other flags clear.
module scan_code_to_ascii_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       scan_valid,
  output logic       scan_ready,
  input  logic [7:0] scan_code,
  output logic       result_valid,
  input  logic       result_ready,
  output logic       char_valid,
  output logic [6:0] char_code,
  output logic       led_write,
  output logic [2:0] led_bits,
  output logic       shift_held,
  output logic       ctrl_held,
  output logic       alt_held
);
  import scad_pkg::*;

  // input stage
  logic [7:0] code;
  logic       code_valid;

  // key and lock state; these drive the status outputs directly
  logic shift_flag, ctrl_flag, alt_flag;
  logic caps_flag, num_flag, scroll_flag;
  logic prefix_pending;

  logic shift_next, ctrl_next, alt_next;
  logic caps_next, num_next, scroll_next;
  logic prefix_next;
  logic led_next;
  ascii_t ch_next;

  logic advance;

  // the decode stage moves when it holds a word and the result slot is free
  assign advance    = code_valid && (!result_valid || result_ready);
  assign scan_ready = !code_valid || advance;

  always_comb begin
    logic [6:0] key;
    logic       pressed;
    logic       in_table;
    ascii_t     plain;
    ascii_t     shifted;
    logic       use_shifted;

    key      = code[6:0];
    pressed  = !code[7];
    in_table = key < 7'(TABLE_ENTRIES);
    plain    = in_table ? PLAIN_MAP[key] : '0;
    shifted  = in_table ? SHIFT_MAP[key] : '0;

    // keypad follows num lock, letters follow shift xor caps, the rest shift
    priority if (key >= KEYPAD_FIRST && key <= KEYPAD_LAST) begin
      use_shifted = num_flag;
    end else if (plain >= ASCII_LC_A && plain <= ASCII_LC_Z) begin
      use_shifted = shift_flag ^ caps_flag;
    end else begin
      use_shifted = shift_flag;
    end

    shift_next  = shift_flag;
    ctrl_next   = ctrl_flag;
    alt_next    = alt_flag;
    caps_next   = caps_flag;
    num_next    = num_flag;
    scroll_next = scroll_flag;
    prefix_next = prefix_pending;
    led_next    = 1'b0;
    ch_next     = '0;

    priority if (code == NULL_CODE) begin
      // null byte: nothing happens, prefix kept
    end else if (code >= PREFIX_MIN && !prefix_pending) begin
      prefix_next = 1'b1;
    end else begin
      // prefixed byte (even another 0xE0+) is treated as its base key
      prefix_next = 1'b0;
      unique case (key)
        KEY_CTRL:   ctrl_next = pressed;
        KEY_LSHIFT,
        KEY_RSHIFT: shift_next = pressed;
        KEY_ALT:    alt_next = pressed;
        KEY_CAPS: begin
          caps_next = caps_flag ^ pressed;
          led_next  = 1'b1;
        end
        KEY_NUM: begin
          num_next = num_flag ^ pressed;
          led_next = 1'b1;
        end
        KEY_SCROLL: begin
          scroll_next = scroll_flag ^ pressed;
          led_next    = 1'b1;
        end
        default: begin
          if (pressed) begin
            ch_next = use_shifted ? shifted : plain;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid     <= 1'b0;
      result_valid   <= 1'b0;
      shift_flag     <= 1'b0;
      ctrl_flag      <= 1'b0;
      alt_flag       <= 1'b0;
      caps_flag      <= 1'b0;
      num_flag       <= 1'b1;
      scroll_flag    <= 1'b0;
      prefix_pending <= 1'b0;
    end else begin
      if (scan_ready) begin
        code_valid <= scan_valid;
      end
      if (advance) begin
        result_valid   <= 1'b1;
        shift_flag     <= shift_next;
        ctrl_flag      <= ctrl_next;
        alt_flag       <= alt_next;
        caps_flag      <= caps_next;
        num_flag       <= num_next;
        scroll_flag    <= scroll_next;
        prefix_pending <= prefix_next;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (scan_valid && scan_ready) begin
      code <= scan_code;
    end
    if (advance) begin
      char_valid <= ch_next != '0;
      char_code  <= ch_next;
      led_write  <= led_next;
    end
  end

  assign led_bits   = {caps_flag, num_flag, scroll_flag};
  assign shift_held = shift_flag;
  assign ctrl_held  = ctrl_flag;
  assign alt_held   = alt_flag;

endmodule

>>> rtl/scad_checker.sv
module scad_checker (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_ready,
  input logic       char_valid,
  input logic [6:0] char_code,
  input logic       led_write,
  input logic [2:0] led_bits,
  input logic       shift_held,
  input logic       ctrl_held,
  input logic       alt_held
);
  import scad_pkg::*;

  // stalled result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(char_code) && $stable(char_valid) && $stable(led_write))
    else $error("result word changed while stalled");

  // char_valid agrees with a nonzero code
  a_char_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (char_valid == (char_code != '0)))
    else $error("char_valid disagrees with char_code");

  // a lock key event never produces a character
  a_led_no_char: assert property (@(posedge clk) disable iff (rst)
    result_valid && led_write |-> !char_valid)
    else $error("LED update and character in one word");

  // after reset: no word, num lock only, no modifiers
  a_reset_state: assert property (@(posedge clk)
    rst |=> !result_valid && led_bits == LED_RESET && !shift_held && !ctrl_held && !alt_held)
    else $error("wrong state after reset");

  // lock and modifier state only move when a word is delivered into the result register
  a_led_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      $stable(led_bits) && $stable(shift_held) && $stable(ctrl_held) && $stable(alt_held))
    else $error("lock or modifier state moved while result stalled");

endmodule

bind scan_code_to_ascii_decoder scad_checker u_scad_checker (.*);
